@@ sv/hsvct_pkg.sv @@
`timescale 1ns / 1ps
package hsvct_pkg;

  localparam int unsigned BOUND_W = 13;
  localparam int unsigned SAT_W   = 9;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned NUM_W   = 21;  // hue numerator, below 5760 * 255
  localparam int unsigned WIDE_W  = 23;  // signed working width for the numerator

  localparam int unsigned SIXTEENTHS_PER_SECTOR = 960;
  localparam int unsigned SIXTEENTHS_FULL_TURN  = 5760;

  localparam logic [BOUND_W-1:0] RANGE_A_LOW_RST  = 13'd3200;
  localparam logic [BOUND_W-1:0] RANGE_A_HIGH_RST = 13'd4000;
  localparam logic [BOUND_W-1:0] RANGE_B_LOW_RST  = 13'd0;
  localparam logic [BOUND_W-1:0] RANGE_B_HIGH_RST = 13'd0;
  localparam logic [SAT_W-1:0]   SAT_MIN_RST      = 9'd154;
  localparam logic [CHAN_W-1:0]  VAL_MIN_RST      = 8'd40;

  typedef enum logic [IDX_W-1:0] {
    REG_RANGE_A_LOW    = 3'd0,
    REG_RANGE_A_HIGH   = 3'd1,
    REG_RANGE_B_LOW    = 3'd2,
    REG_RANGE_B_HIGH   = 3'd3,
    REG_RANGE_B_ENABLE = 3'd4,
    REG_SAT_MIN        = 3'd5,
    REG_VAL_MIN        = 3'd6
  } reg_index_t;

  typedef enum logic [1:0] {
    SECTOR_RED   = 2'd0,
    SECTOR_GREEN = 2'd1,
    SECTOR_BLUE  = 2'd2
  } sector_t;

endpackage

@@ sv/hsv_color_threshold_mask_top.sv @@
`timescale 1ns / 1ps
// hsv color threshold mask
// input channel: in_valid / in_ready with one rgb pixel per request (red, green, blue)
// output channel: out_valid / out_ready with one match flag per pixel, in order
// match is set when saturation >= sat_min/256, value >= val_min and the hue lies
// in range a or, when enabled, range b (a range with low > high wraps through 0)
// path: an accepted pixel passes the max/min, hue numerator, bound products and
// compares and output registers before out_valid
// throughput: one pixel per clock unless stalled; every stage register is a plain
// pipeline stage and bound multiplies are one 13x8 product per bound per stage
// stall: when out_ready is low the output register holds and stages fill in
// behind it; bubbles are squeezed out, so in_ready only drops once every stage
// holds a pixel; nothing is lost or repeated
// configuration: cfg_we writes cfg_data into register cfg_index at once;
// write only while the pipeline is empty
// reset: rst (synchronous) empties the pipeline and loads the default thresholds
module hsv_color_threshold_mask_top
  import hsvct_pkg::*;
#(
  parameter int unsigned NUM_RANGES = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAN_W-1:0] red,
  input  logic [CHAN_W-1:0] green,
  input  logic [CHAN_W-1:0] blue,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              match,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam bit HAS_RANGE_B = (NUM_RANGES >= 2);

  // configuration registers
  logic [BOUND_W-1:0] range_a_low, range_a_high, range_b_low, range_b_high;
  logic               range_b_enable;
  logic [SAT_W-1:0]   sat_min;
  logic [CHAN_W-1:0]  val_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_a_low    <= RANGE_A_LOW_RST;
      range_a_high   <= RANGE_A_HIGH_RST;
      range_b_low    <= RANGE_B_LOW_RST;
      range_b_high   <= RANGE_B_HIGH_RST;
      range_b_enable <= 1'b0;
      sat_min        <= SAT_MIN_RST;
      val_min        <= VAL_MIN_RST;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_RANGE_A_LOW:    range_a_low    <= cfg_data;
        REG_RANGE_A_HIGH:   range_a_high   <= cfg_data;
        REG_RANGE_B_LOW:    range_b_low    <= cfg_data;
        REG_RANGE_B_HIGH:   range_b_high   <= cfg_data;
        REG_RANGE_B_ENABLE: range_b_enable <= cfg_data[0];
        REG_SAT_MIN:        sat_min        <= cfg_data[SAT_W-1:0];
        REG_VAL_MIN:        val_min        <= cfg_data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // stage handshake: a stage advances when it is empty or its successor advances
  logic v1, v2, v3;
  logic adv1, adv2, adv3, adv_out;

  assign adv_out  = !out_valid || out_ready;
  assign adv3     = !v3 || adv_out;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1)    v1        <= in_valid;
      if (adv2)    v2        <= v1;
      if (adv3)    v3        <= v2;
      if (adv_out) out_valid <= v3;
    end
  end

  // stage 1: max, min, delta, sector and signed channel difference
  logic [CHAN_W-1:0] mx_next, mn_next;
  sector_t           sector_next;
  logic signed [CHAN_W:0] diff_next;

  always_comb begin
    mx_next = red;
    if (green > mx_next) mx_next = green;
    if (blue > mx_next)  mx_next = blue;
    mn_next = red;
    if (green < mn_next) mn_next = green;
    if (blue < mn_next)  mn_next = blue;
    // red wins ties, then green
    if (mx_next == red) begin
      sector_next = SECTOR_RED;
      diff_next   = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (mx_next == green) begin
      sector_next = SECTOR_GREEN;
      diff_next   = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      sector_next = SECTOR_BLUE;
      diff_next   = $signed({1'b0, red}) - $signed({1'b0, green});
    end
  end

  logic [CHAN_W-1:0]      mx1, delta1;
  sector_t                sector1;
  logic signed [CHAN_W:0] diff1;

  always_ff @(posedge clk) begin
    if (adv1) begin
      mx1     <= mx_next;
      delta1  <= mx_next - mn_next;
      sector1 <= sector_next;
      diff1   <= diff_next;
    end
  end

  // stage 2: hue numerator, denominator, saturation and value tests
  logic [WIDE_W-1:0] diff_term, sector_off, num_raw, num_wrapped;
  logic [SAT_W+CHAN_W-1:0] sat_prod;
  logic [NUM_W-1:0]  num_next;
  logic [CHAN_W-1:0] den_next;
  logic              s_ok_next, v_ok_next;

  always_comb begin
    diff_term = WIDE_W'(diff1) * WIDE_W'(SIXTEENTHS_PER_SECTOR);
    case (sector1)
      SECTOR_GREEN: sector_off = WIDE_W'(delta1) * WIDE_W'(2 * SIXTEENTHS_PER_SECTOR);
      SECTOR_BLUE:  sector_off = WIDE_W'(delta1) * WIDE_W'(4 * SIXTEENTHS_PER_SECTOR);
      default:      sector_off = '0;
    endcase
    num_raw = diff_term + sector_off;
    // negative numerator wraps by one full turn
    if (num_raw[WIDE_W-1]) begin
      num_wrapped = num_raw + WIDE_W'(delta1) * WIDE_W'(SIXTEENTHS_FULL_TURN);
    end else begin
      num_wrapped = num_raw;
    end
    num_next = num_wrapped[NUM_W-1:0];
    // grey pixel: hue 0 over 1
    den_next = (delta1 == '0) ? CHAN_W'(1) : delta1;
    sat_prod = (SAT_W+CHAN_W)'(sat_min) * (SAT_W+CHAN_W)'(mx1);
    if (delta1 == '0) begin
      s_ok_next = (sat_min == '0);
    end else begin
      s_ok_next = ({1'b0, delta1, 8'b0} >= sat_prod);
    end
    v_ok_next = (mx1 >= val_min);
  end

  logic [NUM_W-1:0]  num2;
  logic [CHAN_W-1:0] den2;
  logic              sv_ok2;

  always_ff @(posedge clk) begin
    if (adv2) begin
      num2   <= num_next;
      den2   <= den_next;
      sv_ok2 <= s_ok_next && v_ok_next;
    end
  end

  // stage 3: bound times denominator, compared against the numerator
  logic [NUM_W-1:0] a_lo_prod, a_hi_prod, b_lo_prod, b_hi_prod;

  assign a_lo_prod = NUM_W'(range_a_low)  * NUM_W'(den2);
  assign a_hi_prod = NUM_W'(range_a_high) * NUM_W'(den2);
  assign b_lo_prod = NUM_W'(range_b_low)  * NUM_W'(den2);
  assign b_hi_prod = NUM_W'(range_b_high) * NUM_W'(den2);

  logic a_ge3, a_le3, b_ge3, b_le3, sv_ok3;

  always_ff @(posedge clk) begin
    if (adv3) begin
      a_ge3  <= (num2 >= a_lo_prod);
      a_le3  <= (num2 <= a_hi_prod);
      b_ge3  <= (num2 >= b_lo_prod);
      b_le3  <= (num2 <= b_hi_prod);
      sv_ok3 <= sv_ok2;
    end
  end

  // stage 4: range combine into the output register
  logic a_in, b_in, match_next;

  always_comb begin
    a_in = (range_a_low <= range_a_high) ? (a_ge3 && a_le3) : (a_ge3 || a_le3);
    b_in = (range_b_low <= range_b_high) ? (b_ge3 && b_le3) : (b_ge3 || b_le3);
    match_next = sv_ok3 && (a_in || (HAS_RANGE_B && range_b_enable && b_in));
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      match <= match_next;
    end
  end

endmodule
